// File: hw/rtl/scwe_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sensor control write encoder.
// No dependencies; used by every module of the block.
package scwe_pkg;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] value;
		logic [7:0]  readback_byte;
	} cmd_t;

	typedef struct packed {
		logic [15:0] reg_address;
		logic [7:0]  reg_data;
		logic        last_write;
	} wr_t;

	typedef enum logic [1:0] {
		KIND_EXPOSURE,
		KIND_GAIN,
		KIND_FLIP
	} kind_t;

	// one classified command; start is the first write step of its run
	typedef struct packed {
		kind_t      kind;
		logic [1:0] start;
		logic       mode_hi;
		logic [7:0] d0;
		logic [7:0] d1;
		logic [7:0] d2;
	} rec_t;

	localparam logic [1:0] OpExposure = 2'd0;
	localparam logic [1:0] OpGain     = 2'd1;
	localparam logic [1:0] OpFlip     = 2'd2;

	localparam logic [1:0] StepMode = 2'd0;
	localparam logic [1:0] StepD0   = 2'd1;
	localparam logic [1:0] StepD1   = 2'd2;
	localparam logic [1:0] StepLast = 2'd3;

	localparam logic [15:0] FrameLinesReset = 16'd2700;

	localparam logic [15:0] AddrGainMode = 16'h3804;
	localparam logic [15:0] AddrGainIdx  = 16'h3154;
	localparam logic [15:0] AddrCoarseHi = 16'h314D;
	localparam logic [15:0] AddrCoarseLo = 16'h314C;
	localparam logic [15:0] AddrExpoHi   = 16'h304A;
	localparam logic [15:0] AddrExpoMid  = 16'h3049;
	localparam logic [15:0] AddrExpoLo   = 16'h3048;
	localparam logic [15:0] AddrOrient   = 16'h3028;

	localparam logic [7:0] ModeLow  = 8'h10;
	localparam logic [7:0] ModeHigh = 8'h15;
	localparam logic [7:0] OrientKeepMask = 8'hFC;

	localparam logic [31:0] ExpoFloor  = 32'd8;
	localparam logic [31:0] ExpoMargin = 32'd4;

	localparam logic [31:0] GainModeLowMax  = 32'h400;
	localparam logic [31:0] GainModeHighMin = 32'h800;

	localparam logic [26:0] CoarseMin = 27'h40;
	localparam logic [26:0] CoarseMax = 27'h3FF;
	localparam logic [10:0] CoarseSat = 11'h400;

	// gain ROM breakpoints: step 4 up to 264, step 8 up to 1024
	localparam logic [31:0] GainRomMin   = 32'd64;
	localparam logic [31:0] GainRomFine  = 32'd264;
	localparam logic [31:0] GainRomMax   = 32'd1024;
	localparam logic [8:0]  GainFineRows = 9'd50;

endpackage

// File: hw/rtl/scwe_front.sv
`timescale 1ns / 1ps
// Front end: accepts command beats, computes exposure, gain and orientation
// values and registers one classified record. Depends on scwe_pkg.
module scwe_front #(
	parameter int GAIN_STEPS = 250
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  scwe_pkg::cmd_t      in_data,
	input  logic [15:0]         frame_lines,
	output logic                rec_valid,
	input  logic                rec_ready,
	output scwe_pkg::rec_t      rec
);

	localparam logic [8:0] LastIdx = 9'(GAIN_STEPS - 1);

	logic           rec_valid_s1;
	scwe_pkg::rec_t rec_s1;
	scwe_pkg::rec_t rec_next;
	logic           op_known;

	logic [31:0] fl32, v_raw, v_floor, v_cap, v_expo;
	logic [31:0] g;
	logic [10:0] lin;
	logic [8:0]  q4, j_fine, j_coarse, j;
	logic [7:0]  gain_idx;
	logic [10:0] coarse;
	logic        has_mode;
	logic [7:0]  orient;

	assign in_stall = rec_valid_s1 & ~rec_ready;
	assign rec_valid = rec_valid_s1;
	assign rec = rec_s1;

	assign fl32    = {16'd0, frame_lines};
	assign v_raw   = fl32 - {in_data.value[30:0], 1'b0};
	assign v_cap   = fl32 - scwe_pkg::ExpoMargin;
	assign v_floor = (v_raw < scwe_pkg::ExpoFloor) ? scwe_pkg::ExpoFloor : v_raw;
	assign v_expo  = (v_floor > v_cap) ? v_cap : v_floor;

	// first ROM row j >= 1 with t(j) >= gain; index is j - 1
	assign g        = in_data.value;
	assign lin      = g[10:0];
	assign q4       = 9'((lin - 11'd61) >> 2);
	assign j_fine   = (q4 == 9'd0) ? 9'd1 : q4;
	assign j_coarse = scwe_pkg::GainFineRows + 9'((lin - 11'd257) >> 3);
	assign j        = (g <= scwe_pkg::GainRomFine) ? j_fine : j_coarse;

	always_comb begin
		if (g < scwe_pkg::GainRomMin || g > scwe_pkg::GainRomMax || j > LastIdx) begin
			gain_idx = LastIdx[7:0];
		end else begin
			gain_idx = 8'(j - 9'd1);
		end
	end

	always_comb begin
		if (g[31:5] > scwe_pkg::CoarseMax) begin
			coarse = scwe_pkg::CoarseSat;
		end else if (g[31:5] < scwe_pkg::CoarseMin) begin
			coarse = scwe_pkg::CoarseMin[10:0];
		end else begin
			coarse = g[15:5];
		end
	end

	assign has_mode = (g <= scwe_pkg::GainModeLowMax) || (g >= scwe_pkg::GainModeHighMin);
	assign orient = (in_data.readback_byte & scwe_pkg::OrientKeepMask)
		| {6'd0, in_data.value[0], in_data.value[1]};

	always_comb begin
		rec_next = '0;
		op_known = 1'b1;
		unique case (in_data.operation)
			scwe_pkg::OpExposure: begin
				rec_next.kind  = scwe_pkg::KIND_EXPOSURE;
				rec_next.start = scwe_pkg::StepD0;
				rec_next.d0    = v_expo[23:16];
				rec_next.d1    = v_expo[15:8];
				rec_next.d2    = v_expo[7:0];
			end
			scwe_pkg::OpGain: begin
				rec_next.kind    = scwe_pkg::KIND_GAIN;
				rec_next.start   = has_mode ? scwe_pkg::StepMode : scwe_pkg::StepD0;
				rec_next.mode_hi = g >= scwe_pkg::GainModeHighMin;
				rec_next.d0      = gain_idx;
				rec_next.d1      = {5'd0, coarse[10:8]};
				rec_next.d2      = coarse[7:0];
			end
			scwe_pkg::OpFlip: begin
				rec_next.kind  = scwe_pkg::KIND_FLIP;
				rec_next.start = scwe_pkg::StepLast;
				rec_next.d2    = orient;
			end
			default: begin
				op_known = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			rec_valid_s1 <= in_valid & op_known;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			rec_s1 <= rec_next;
		end
	end

endmodule

// File: hw/rtl/scwe_fifo.sv
`timescale 1ns / 1ps
// Short record queue between front end and write sequencer.
// Depends on scwe_pkg for the record type.
module scwe_fifo #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  scwe_pkg::rec_t push_data,
	output logic           head_valid,
	input  logic           pop,
	output scwe_pkg::rec_t head
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

	scwe_pkg::rec_t  mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            push;

	assign push_ready = count_q != CntFull;
	assign head_valid = count_q != '0;
	assign head = mem_q[rd_ptr_q];
	assign push = push_valid & push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: hw/rtl/scwe_back.sv
`timescale 1ns / 1ps
// Write sequencer: steps through the head record and drives one register
// write beat per unstalled cycle to the output register; needs scwe_pkg.
module scwe_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  scwe_pkg::rec_t head,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output scwe_pkg::wr_t  out_data
);

	logic          out_valid_q;
	scwe_pkg::wr_t out_data_q;
	logic          started_q;
	logic [1:0]    step_q;
	logic [1:0]    cur_step;
	logic          emit;
	scwe_pkg::wr_t beat;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign emit      = head_valid & (~out_valid_q | ~out_stall);
	assign cur_step  = started_q ? step_q : head.start;
	assign pop       = emit & (cur_step == scwe_pkg::StepLast);

	always_comb begin
		beat.last_write = cur_step == scwe_pkg::StepLast;
		beat.reg_address = scwe_pkg::AddrGainMode;
		beat.reg_data = head.mode_hi ? scwe_pkg::ModeHigh : scwe_pkg::ModeLow;
		unique case (cur_step)
			scwe_pkg::StepMode: begin
			end
			scwe_pkg::StepD0: begin
				beat.reg_data = head.d0;
				beat.reg_address = (head.kind == scwe_pkg::KIND_EXPOSURE)
					? scwe_pkg::AddrExpoHi : scwe_pkg::AddrGainIdx;
			end
			scwe_pkg::StepD1: begin
				beat.reg_data = head.d1;
				beat.reg_address = (head.kind == scwe_pkg::KIND_EXPOSURE)
					? scwe_pkg::AddrExpoMid : scwe_pkg::AddrCoarseHi;
			end
			scwe_pkg::StepLast: begin
				beat.reg_data = head.d2;
				unique case (head.kind)
					scwe_pkg::KIND_EXPOSURE: beat.reg_address = scwe_pkg::AddrExpoLo;
					scwe_pkg::KIND_GAIN:     beat.reg_address = scwe_pkg::AddrCoarseLo;
					default:                 beat.reg_address = scwe_pkg::AddrOrient;
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			started_q   <= 1'b0;
			step_q      <= scwe_pkg::StepMode;
		end else begin
			if (!out_valid_q || !out_stall) begin
				out_valid_q <= head_valid;
			end
			if (emit) begin
				started_q <= ~pop;
				step_q    <= cur_step + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= beat;
		end
	end

	// a run in progress always has its record at the queue head
	a_run_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |-> head_valid)
		else $error("write run in progress without a queued record");

	// the record leaves the queue exactly with its last write
	a_pop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q && out_data_q.last_write)
		else $error("record popped without a last write beat");

	// a mid-run step never goes back to the mode write
	a_step_forward: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |-> step_q != scwe_pkg::StepMode)
		else $error("sequencer stepped back to the mode write");

endmodule

// File: hw/rtl/sensor_control_write_encoder_core.sv
`timescale 1ns / 1ps
// Top level of the sensor control write encoder: front end, record queue,
// write sequencer and the frame_lines register. Depends on scwe_pkg.
//
// Each command beat becomes a run of 16-bit address / 8-bit data writes:
// three for exposure, three or four for gain, one for mirror/flip, none for
// the unused operation code. The last beat of a run has last_write set.
// The sequencer drives one write per cycle while the output is not stalled,
// so the sustained rate is set by that one-write-per-cycle output. Commands
// are taken every cycle while the FIFO_DEPTH-entry record queue has room. A
// command passes through the front-end record register and the record queue
// before its first write is registered at the sequencer output. frame_lines
// is written through cfg, which is always ready, and resets to 2700.
module sensor_control_write_encoder_core #(
	parameter int GAIN_STEPS = 250,
	parameter int FIFO_DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  scwe_pkg::cmd_t in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output scwe_pkg::wr_t  out_data,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [15:0]    cfg_data
);

	logic [15:0]    frame_lines_q;
	logic           rec_valid, rec_ready;
	scwe_pkg::rec_t rec;
	logic           head_valid, pop;
	scwe_pkg::rec_t head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_lines_q <= scwe_pkg::FrameLinesReset;
		end else if (cfg_valid && cfg_ready) begin
			frame_lines_q <= cfg_data;
		end
	end

	scwe_front #(
		.GAIN_STEPS(GAIN_STEPS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.frame_lines(frame_lines_q),
		.rec_valid  (rec_valid),
		.rec_ready  (rec_ready),
		.rec        (rec)
	);

	scwe_fifo #(
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(rec_valid),
		.push_ready(rec_ready),
		.push_data (rec),
		.head_valid(head_valid),
		.pop       (pop),
		.head      (head)
	);

	scwe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
